/* sv/osc_sequence_parser_unit_defines.svh */
// ----------------------------------------------------------------------------
// OSC sequence parser assertion macros
// Shared concurrent assertion forms, clocked on i_clk, gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef OSC_SEQUENCE_PARSER_UNIT_DEFINES_SVH
`define OSC_SEQUENCE_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define OSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/osp_pkg.sv */
// ----------------------------------------------------------------------------
// OSC sequence parser package
// Result types, role and status codes, and command and byte constants.
// ----------------------------------------------------------------------------
package osp_pkg;

    localparam logic [3:0]  MAX_PARAMS   = 4'd8;
    localparam logic [15:0] CMD_LINK     = 16'd8;
    localparam logic [15:0] CMD_NT_A     = 16'd110;
    localparam logic [15:0] CMD_NT_B     = 16'd111;
    localparam logic [15:0] CMD_NT_C     = 16'd112;
    localparam logic [15:0] CMD_SAT      = 16'hFFFF;
    localparam logic [7:0]  CH_SEMI      = 8'h3B;
    localparam logic [7:0]  CH_EQUAL     = 8'h3D;
    localparam logic [7:0]  CH_COLON     = 8'h3A;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [7:0]  CH_NINE      = 8'h39;

    typedef enum logic [2:0] {
        ROLE_DIGIT   = 3'd0,
        ROLE_DELIM   = 3'd1,
        ROLE_KEY     = 3'd2,
        ROLE_VALUE   = 3'd3,
        ROLE_TEXT    = 3'd4,
        ROLE_IGNORED = 3'd5
    } t_role;

    typedef enum logic [1:0] {
        ST_UNDECIDED = 2'd0,
        ST_ACCEPTED  = 2'd1,
        ST_REJECTED  = 2'd2
    } t_status;

    typedef struct packed {
        t_role       byte_role;
        logic [2:0]  param_index;
        t_status     status;
        logic [15:0] command_number;
        logic [3:0]  param_count;
    } t_result;

endpackage

/* sv/osp_ifs.sv */
// ----------------------------------------------------------------------------
// OSC sequence parser channels
// Valid/ready stream interfaces for body bytes and tagged results.
// ----------------------------------------------------------------------------
interface osp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface osp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic [2:0]  param_index;
    logic [1:0]  status;
    logic [15:0] command_number;
    logic [3:0]  param_count;

    modport source (output valid, output byte_role, output param_index, output status,
                    output command_number, output param_count, input ready);
    modport sink   (input valid, input byte_role, input param_index, input status,
                    input command_number, input param_count, output ready);
endinterface

/* sv/osp_core.sv */
// ----------------------------------------------------------------------------
// OSC sequence parser core
// Parse state and one-byte step; state advances on each accepted byte.
// ----------------------------------------------------------------------------
module osp_core
    import osp_pkg::*;
#(
    parameter logic [3:0] P_MAX_PARAMS = MAX_PARAMS
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output t_result    o_result
);

    typedef enum logic [2:0] {
        PH_CMD    = 3'd0,
        PH_PSTART = 3'd1,
        PH_KEY    = 3'd2,
        PH_VALUE  = 3'd3,
        PH_TEXT   = 3'd4,
        PH_ACCEPT = 3'd5,
        PH_REJECT = 3'd6
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [3:0]  r_params, n_params;

    logic [19:0] w_prod;
    logic [3:0]  w_params_inc;
    logic        w_digit;
    t_role       w_role;
    logic [2:0]  w_pidx;
    t_status     w_status;

    function automatic logic no_text(input logic [15:0] c);
        return (c == CMD_NT_A) || (c == CMD_NT_B) || (c == CMD_NT_C);
    endfunction

    // digits 0x30..0x39 carry their value in the low nibble
    assign w_prod       = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                        + {16'b0, i_data_byte[3:0]};
    assign w_params_inc = r_params + 4'd1;
    assign w_digit      = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_params = r_params;
        w_role   = ROLE_IGNORED;
        w_pidx   = '0;

        case (r_phase)
            PH_CMD: begin
                if (w_digit) begin
                    n_acc  = (w_prod > {4'b0, CMD_SAT}) ? CMD_SAT : w_prod[15:0];
                    w_role = ROLE_DIGIT;
                end else if (r_acc == CMD_LINK) begin
                    if (i_data_byte == CH_SEMI) begin
                        w_role  = ROLE_DELIM;
                        n_phase = PH_PSTART;
                    end else begin
                        n_phase = PH_REJECT;
                    end
                end else if (i_data_byte == CH_SEMI) begin
                    w_role  = ROLE_DELIM;
                    n_phase = PH_TEXT;
                end else if (no_text(r_acc)) begin
                    n_phase = PH_ACCEPT;
                end else begin
                    n_phase = PH_REJECT;
                end
            end
            PH_PSTART, PH_KEY: begin
                if (r_phase == PH_PSTART && i_data_byte == CH_SEMI) begin
                    w_role  = ROLE_DELIM;
                    n_phase = PH_TEXT;
                end else if (i_data_byte == CH_EQUAL) begin
                    w_role  = ROLE_DELIM;
                    n_phase = PH_VALUE;
                end else begin
                    w_role  = ROLE_KEY;
                    w_pidx  = r_params[2:0];
                    n_phase = PH_KEY;
                end
            end
            PH_VALUE: begin
                if (i_data_byte == CH_COLON || i_data_byte == CH_SEMI) begin
                    w_role   = ROLE_DELIM;
                    n_params = w_params_inc;
                    if (i_data_byte == CH_SEMI) begin
                        n_phase = PH_TEXT;
                    end else if (w_params_inc >= P_MAX_PARAMS) begin
                        n_phase = PH_REJECT;
                    end else begin
                        n_phase = PH_KEY;
                    end
                end else begin
                    w_role = ROLE_VALUE;
                    w_pidx = r_params[2:0];
                end
            end
            PH_TEXT: begin
                w_role = ROLE_TEXT;
            end
            default: begin
                w_role = ROLE_IGNORED;
            end
        endcase

        // body ended before a verdict
        if (i_last_byte) begin
            if (n_phase == PH_CMD) begin
                n_phase = (n_acc != CMD_LINK && no_text(n_acc)) ? PH_ACCEPT : PH_REJECT;
            end else if (n_phase == PH_PSTART || n_phase == PH_KEY || n_phase == PH_VALUE) begin
                n_phase = PH_REJECT;
            end
        end

        case (n_phase)
            PH_TEXT, PH_ACCEPT: w_status = ST_ACCEPTED;
            PH_REJECT:          w_status = ST_REJECTED;
            default:            w_status = ST_UNDECIDED;
        endcase
    end

    assign o_result.byte_role      = w_role;
    assign o_result.param_index    = w_pidx;
    assign o_result.status         = w_status;
    assign o_result.command_number = n_acc;
    assign o_result.param_count    = n_params;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CMD;
            r_acc    <= '0;
            r_params <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_phase  <= PH_CMD;
                r_acc    <= '0;
                r_params <= '0;
            end else begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_params <= n_params;
            end
        end
    end

endmodule

/* sv/osc_sequence_parser_unit.sv */
// ----------------------------------------------------------------------------
// OSC sequence parser unit
// Tags each byte of an OSC body with its role and the running verdict.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one body byte per transfer, last_byte marking the final one.
//   o_out carries one result per input byte: role, parameter index, status,
//   saturated command number and count of completed parameters.
//   Timing: results are valid the cycle after transfer unless output stalls.
//   Throughput: one byte per cycle while the skid register is empty; the
//   parse step is a single combinational pass, parse state to result register.
//   Stall: a result held by the receiver does not block input; one more byte
//   is taken into a skid register, then i_in.ready drops until it drains.
//   Reset: parse state returns to the command-digit phase and both result
//   registers empty. After each final byte the parse state also returns
//   to that phase, ready for the next sequence.
// ----------------------------------------------------------------------------
`include "osc_sequence_parser_unit_defines.svh"

module osc_sequence_parser_unit
    import osp_pkg::*;
#(
    parameter logic [3:0] P_MAX_PARAMS = MAX_PARAMS
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    osp_in_if.sink            i_in,
    osp_out_if.source         o_out
);

    t_result w_result;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    w_accept, w_take;

    assign i_in.ready = !r_skid_valid;
    assign w_accept   = i_in.valid && !r_skid_valid;
    assign w_take     = r_out_valid && o_out.ready;

    osp_core #(
        .P_MAX_PARAMS (P_MAX_PARAMS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_result;
            end
        end else if (w_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.byte_role      = r_out.byte_role;
    assign o_out.param_index    = r_out.param_index;
    assign o_out.status         = r_out.status;
    assign o_out.command_number = r_out.command_number;
    assign o_out.param_count    = r_out.param_count;

    `OSP_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full while output empty")
    `OSP_ASSERT_NEXT(a_stall_fills_skid, w_accept && r_out_valid && !o_out.ready, r_skid_valid, "stalled transfer lost")
    `OSP_ASSERT_NOW(a_pidx_role, r_out_valid && r_out.param_index != 3'd0, r_out.byte_role == ROLE_KEY || r_out.byte_role == ROLE_VALUE, "param index on non-parameter byte")
    `OSP_ASSERT_NOW(a_text_accepted, r_out_valid && r_out.byte_role == ROLE_TEXT, r_out.status == ST_ACCEPTED, "text byte without acceptance")

endmodule
